[rtl/core/afsd_pkg.sv]
// shared types and constants of the accelerometer fifo sample decoder
package afsd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 24;
	localparam int unsigned COUNT_W  = 20;
	localparam int unsigned ACCEL_W  = 28;
	localparam int unsigned POS_W    = 4;
	localparam int unsigned RANGE_W  = 2;

	// last byte position of a nine-byte sample
	localparam logic [POS_W-1:0] LAST_POS = 4'd8;
	// byte positions where the y and z words begin
	localparam logic [POS_W-1:0] Y_POS = 4'd3;
	localparam logic [POS_W-1:0] Z_POS = 4'd6;

	// tenth-microg per lsb at 2g; 4g and 8g are one and two doublings of it
	localparam logic signed [ACCEL_W-1:0] SCALE_BASE = 28'sd39;

	// full-scale range codes
	localparam logic [RANGE_W-1:0] RANGE_2G = 2'd0;
	localparam logic [RANGE_W-1:0] RANGE_4G = 2'd1;
	localparam logic [RANGE_W-1:0] RANGE_8G = 2'd2;

	// axis word index
	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	// frame check outcome
	typedef enum logic [1:0] {
		FRAME_OK,
		FRAME_NO_X_MARK,
		FRAME_STRAY_MARK,
		FRAME_EMPTY_SET
	} frame_err_t;

	// one input request
	typedef struct packed {
		logic [BYTE_W-1:0] fifo_byte;
		logic              burst_start;
	} in_req_t;

	// one decoded sample
	typedef struct packed {
		logic signed [ACCEL_W-1:0] x_accel;
		logic signed [ACCEL_W-1:0] y_accel;
		logic signed [ACCEL_W-1:0] z_accel;
		frame_err_t                frame_error;
	} result_t;

endpackage

[rtl/core/afsd_in_reg.sv]
// input register stage holding one accepted byte request
module afsd_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  afsd_pkg::in_req_t in_req,
	input  logic             advance,
	output logic             valid_s1,
	output afsd_pkg::in_req_t req_s1
);
	import afsd_pkg::*;

	// room when empty or when the held request moves on this cycle
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_req;
		end
	end

endmodule

[rtl/core/afsd_frame.sv]
// sample assembly, marker checks and scaling for one byte request a cycle while step is high
module afsd_frame (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  afsd_pkg::in_req_t                req,
	input  logic [afsd_pkg::RANGE_W-1:0]     range_sel,
	output logic                             res_valid,
	output afsd_pkg::result_t                res
);
	import afsd_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic              aborted_q;
	logic [WORD_W-1:0] words_q [3];

	logic [POS_W-1:0]  pos_eff;
	logic              abort_eff;
	logic              take;
	logic              last;
	axis_t             axis;
	logic [WORD_W-1:0] words_n [3];
	logic [BYTE_W-1:0] lx, ly, lz;
	frame_err_t        err;
	logic signed [ACCEL_W-1:0] cnt [3];
	logic signed [ACCEL_W-1:0] p39 [3];
	logic signed [ACCEL_W-1:0] scaled [3];

	// burst start clears position and abort before the byte is used
	always_comb begin
		pos_eff   = req.burst_start ? '0 : pos_q;
		abort_eff = req.burst_start ? 1'b0 : aborted_q;
		take      = step && !abort_eff;
		last      = take && (pos_eff >= LAST_POS);
	end

	// axis the byte belongs to
	always_comb begin
		priority if (pos_eff >= Z_POS) begin
			axis = AXIS_Z;
		end else if (pos_eff >= Y_POS) begin
			axis = AXIS_Y;
		end else begin
			axis = AXIS_X;
		end
	end

	// shift the byte into its axis word, msb first
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			words_n[i] = words_q[i];
		end
		if (take) begin
			words_n[axis] = {words_q[axis][WORD_W-BYTE_W-1:0], req.fifo_byte};
		end
	end

	// marker checks, first failing test wins
	always_comb begin
		lx = words_n[AXIS_X][BYTE_W-1:0];
		ly = words_n[AXIS_Y][BYTE_W-1:0];
		lz = words_n[AXIS_Z][BYTE_W-1:0];
		priority if (!lx[0]) begin
			err = FRAME_NO_X_MARK;
		end else if (ly[0] || lz[0]) begin
			err = FRAME_STRAY_MARK;
		end else if (lx[1] || ly[1] || lz[1]) begin
			err = FRAME_EMPTY_SET;
		end else begin
			err = FRAME_OK;
		end
	end

	// signed 20-bit count times the range scale
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cnt[i] = {{(ACCEL_W-COUNT_W){words_n[i][WORD_W-1]}},
				words_n[i][WORD_W-1:WORD_W-COUNT_W]};
			p39[i] = cnt[i] * SCALE_BASE;
			unique case (range_sel)
				RANGE_2G: scaled[i] = p39[i];
				RANGE_4G: scaled[i] = p39[i] <<< 1;
				default:  scaled[i] = p39[i] <<< 2;
			endcase
		end
	end

	// result on the ninth byte; zeros on a failed check
	always_comb begin
		res_valid       = last;
		res.frame_error = err;
		if (err == FRAME_OK) begin
			res.x_accel = scaled[AXIS_X];
			res.y_accel = scaled[AXIS_Y];
			res.z_accel = scaled[AXIS_Z];
		end else begin
			res.x_accel = '0;
			res.y_accel = '0;
			res.z_accel = '0;
		end
	end

	// position and abort state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			aborted_q <= 1'b0;
		end else if (take) begin
			pos_q     <= last ? '0 : pos_eff + 4'd1;
			aborted_q <= last && (err != FRAME_OK);
		end
	end

	// axis words
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 3; i++) begin
				words_q[i] <= words_n[i];
			end
		end
	end

endmodule

[rtl/core/afsd_out_reg.sv]
// result register on the output side
module afsd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  afsd_pkg::result_t res,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_ready,
	output afsd_pkg::result_t out_res
);
	import afsd_pkg::*;

	// free when empty or being taken this cycle
	assign can_load = !out_valid || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			out_res <= res;
		end
	end

endmodule

[rtl/core/accel_fifo_sample_decoder.sv]
// top level of the accelerometer fifo sample decoder
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+------------------------
//  input    | fifo_byte, burst_start                   | in_valid / in_ready
//  output   | x_accel, y_accel, z_accel, frame_error   | out_valid / out_ready
//  config   | range_select_wdata                       | range_select_we, no wait
//
// One byte request is accepted per cycle while in_ready is high. A byte is
// held in the input register and is decoded from there when the result
// register can take its outcome; the ninth byte of a sample loads the
// result register, which sets out_valid. Reset clears the byte position,
// the abort flag, both valid flags and the range (2g). A stall on the output
// holds the input register once it holds a byte, and in_ready then stays low
// until the waiting result is taken.
module accel_fifo_sample_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    fifo_byte,
	input  logic                          burst_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [27:0]            x_accel,
	output logic signed [27:0]            y_accel,
	output logic signed [27:0]            z_accel,
	output logic [1:0]                    frame_error,
	input  logic                          range_select_we,
	input  logic [1:0]                    range_select_wdata
);
	import afsd_pkg::*;

	logic [RANGE_W-1:0] range_q;
	in_req_t            in_req;
	in_req_t            req_s1;
	logic               valid_s1;
	logic               can_load;
	logic               advance;
	logic               res_valid;
	result_t            res;
	result_t            out_res;

	// range register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_2G;
		end else if (range_select_we) begin
			range_q <= range_select_wdata;
		end
	end

	// request bundle
	assign in_req.fifo_byte   = fifo_byte;
	assign in_req.burst_start = burst_start;

	// held byte is decoded when the result register can take its outcome
	assign advance = valid_s1 && can_load;

	afsd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	afsd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.req       (req_s1),
		.range_sel (range_q),
		.res_valid (res_valid),
		.res       (res)
	);

	afsd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// result fields
	assign x_accel     = out_res.x_accel;
	assign y_accel     = out_res.y_accel;
	assign z_accel     = out_res.z_accel;
	assign frame_error = out_res.frame_error;

endmodule
